@@ src/vwgb_pkg.sv @@
// Shared types, codes and constants of the variable-width glyph blitter.
`timescale 1ns / 1ps
package vwgb_pkg;

  localparam int GLYPH_ROWS    = 16;
  localparam int GLYPH_HALF    = GLYPH_ROWS / 2;
  localparam int DEF_MAX_BOX_W = 32;
  localparam int DEF_MAX_BOX_H = 24;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [5:0]  RST_BOX_W = 6'd32;
  localparam logic [4:0]  RST_BOX_H = 5'd24;
  localparam logic [7:0]  RST_INK   = 8'd1;
  localparam logic [15:0] RST_BASE  = 16'd0;

  typedef enum logic [1:0] {
    OP_ROW     = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_HOME    = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_REPORT   = 2'd1,
    KIND_REFUSED  = 2'd2,
    KIND_ACCEPTED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_BOX_W = 2'd0,
    CFG_BOX_H = 2'd1,
    CFG_INK   = 2'd2,
    CFG_BASE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    D_WRITE  = 2'd0,
    D_REFUSE = 2'd1,
    D_ACCEPT = 2'd2
  } dkind_t;

  typedef struct packed {
    logic [5:0]  box_w;
    logic [4:0]  box_h;
    logic [7:0]  ink;
    logic [15:0] base;
  } cfg_t;

  typedef struct packed {
    dkind_t      dkind;
    logic        marker;
    logic [4:0]  cur_row;
    logic        lower;
    logic [5:0]  col;
    logic [2:0]  offset;
    logic [2:0]  y;
    logic [63:0] pixels;
  } desc_t;

endpackage

@@ src/vwgb_front.sv @@
// Front end: cursor tracking, wrap and refusal decisions, work descriptors.
`timescale 1ns / 1ps
module vwgb_front
  import vwgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [1:0]  opcode,
  input  logic [3:0]  row_number,
  input  logic [63:0] row_pixels,
  input  logic [3:0]  glyph_width,
  input  logic        is_marker,
  output logic        desc_push,
  output desc_t       desc
);

  logic [4:0] row_r, row_nxt;
  logic [5:0] col_r, col_nxt;
  logic [2:0] off_r, off_nxt;
  logic       refused_r, refused_nxt;

  logic [9:0] span;
  logic       need_wrap;
  logic       no_room;
  logic [4:0] off_sum;

  function automatic logic [8:0] box_w_x8(input logic [5:0] w);
    box_w_x8 = {w, 3'b000};
  endfunction

  assign span      = {1'b0, col_r, 3'b000} + 10'(off_r) + 10'(glyph_width);
  assign need_wrap = span >= {1'b0, box_w_x8(cfg.box_w)};
  assign no_room   = ({1'b0, row_r} + 6'd2) >= {1'b0, cfg.box_h};

  always_comb begin
    row_nxt     = row_r;
    col_nxt     = col_r;
    off_nxt     = off_r;
    refused_nxt = refused_r;
    desc_push   = 1'b0;
    off_sum     = 5'd0;
    desc        = '0;
    desc.dkind  = D_ACCEPT;
    desc.pixels = row_pixels;
    desc.y      = row_number[2:0];
    desc.lower  = row_number >= 4'(GLYPH_HALF);
    case (opcode)
      OP_NEWLINE: begin
        desc_push = 1'b1;
        if (no_room) begin
          desc.dkind = D_REFUSE;
        end else begin
          row_nxt = row_r + 5'd2;
          col_nxt = 6'd0;
          off_nxt = 3'd0;
        end
      end
      OP_HOME: begin
        desc_push = 1'b1;
        row_nxt   = 5'd0;
        col_nxt   = 6'd0;
        off_nxt   = 3'd0;
      end
      OP_ROW: begin
        desc_push = 1'b1;
        if (row_number == 4'd0) begin
          refused_nxt = 1'b0;
          if (need_wrap) begin
            if (no_room) begin
              refused_nxt = 1'b1;
            end else begin
              row_nxt = row_r + 5'd2;
              col_nxt = 6'd0;
              off_nxt = 3'd0;
            end
          end
        end
        if (refused_nxt) begin
          desc.dkind = D_REFUSE;
        end else begin
          desc.dkind   = D_WRITE;
          desc.marker  = is_marker && (row_number == 4'd0);
          desc.cur_row = row_nxt;
          desc.col     = col_nxt;
          desc.offset  = off_nxt;
          if (row_number == 4'(GLYPH_ROWS - 1)) begin
            off_sum = 5'(off_nxt) + 5'(glyph_width);
            col_nxt = col_nxt + 6'(off_sum[4:3]);
            off_nxt = off_sum[2:0];
          end
        end
      end
      default: begin
        desc_push = 1'b0;
      end
    endcase
    if (!accept) begin
      desc_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= 5'd0;
      col_r     <= 6'd0;
      off_r     <= 3'd0;
      refused_r <= 1'b0;
    end else if (accept) begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      off_r     <= off_nxt;
      refused_r <= refused_nxt;
    end
  end

endmodule

@@ src/vwgb_queue.sv @@
// Small descriptor FIFO between the front end and the write sequencer.
`timescale 1ns / 1ps
module vwgb_queue
  import vwgb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t din,
  output logic  full,
  input  logic  pop,
  output desc_t dout,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  desc_t             mem_r [DEPTH];
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == (AW + 1)'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

@@ src/vwgb_back.sv @@
// Back end: descriptors to reports, OR-writes, status; one per cycle if popped.
`timescale 1ns / 1ps
module vwgb_back
  import vwgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  desc_t        desc,
  input  logic         desc_empty,
  output logic         desc_pop,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [1:0]   out_kind,
  output logic [16:0]  out_write_address,
  output logic [63:0]  out_or_data,
  output logic [8:0]   out_report_x,
  output logic [8:0]   out_report_y,
  output logic         out_last
);

  logic [1:0]   step_r, step_nxt;
  logic [1:0]   phase;
  logic         load;
  logic         is_last;

  logic         valid_r, valid_nxt;
  logic [1:0]   kind_r, kind_nxt;
  logic [16:0]  addr_r, addr_nxt;
  logic [63:0]  data_r, data_nxt;
  logic [8:0]   rx_r, rx_nxt;
  logic [8:0]   ry_r, ry_nxt;
  logic         last_r, last_nxt;

  logic [5:0]   trow;
  logic [11:0]  prod;
  logic [12:0]  tile_idx;
  logic [16:0]  left_addr;
  logic [63:0]  masked;
  logic [127:0] shifted;

  assign load  = !desc_empty && (!valid_r || out_pop);
  assign phase = desc.marker ? step_r : step_r + 2'd1;

  assign trow      = {1'b0, desc.cur_row} + 6'(desc.lower);
  assign prod      = cfg.box_w * trow;
  assign tile_idx  = 13'(prod) + 13'(desc.col);
  assign left_addr = 17'(cfg.base) + {tile_idx[10:0], 6'd0} + 17'({desc.y, 3'b000});
  assign masked    = desc.pixels & {8{cfg.ink}};
  assign shifted   = {64'd0, masked} << {desc.offset, 3'b000};

  always_comb begin
    is_last  = 1'b1;
    kind_nxt = KIND_ACCEPTED;
    addr_nxt = 17'd0;
    data_nxt = 64'd0;
    rx_nxt   = 9'd0;
    ry_nxt   = 9'd0;
    case (desc.dkind)
      D_WRITE: begin
        case (phase)
          2'd0: begin
            is_last  = 1'b0;
            kind_nxt = KIND_REPORT;
            rx_nxt   = {desc.col, desc.offset};
            ry_nxt   = {desc.cur_row, 4'd0};
          end
          2'd1: begin
            is_last  = 1'b0;
            kind_nxt = KIND_WRITE;
            addr_nxt = left_addr;
            data_nxt = shifted[63:0];
          end
          default: begin
            kind_nxt = KIND_WRITE;
            addr_nxt = left_addr + 17'd64;
            data_nxt = shifted[127:64];
          end
        endcase
      end
      D_REFUSE: kind_nxt = KIND_REFUSED;
      default:  kind_nxt = KIND_ACCEPTED;
    endcase
    last_nxt = is_last;
  end

  assign desc_pop  = load && is_last;
  assign step_nxt  = !load ? step_r : (is_last ? 2'd0 : step_r + 2'd1);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_empty         = !valid_r;
  assign out_kind          = kind_r;
  assign out_write_address = addr_r;
  assign out_or_data       = data_r;
  assign out_report_x      = rx_r;
  assign out_report_y      = ry_r;
  assign out_last          = last_r;

endmodule

@@ src/variable_width_glyph_blitter_unit.sv @@
// Top level of the variable-width glyph blitter: config registers and the two halves.
//
// Items enter on the in_ channel (push/full) and results leave on the out_ channel
// (empty/pop). An item is one glyph row, a newline or a cursor home. A glyph row
// gives an OR-write to the tile under the cursor and one to the tile to its right,
// preceded on row 0 of a marker glyph by a position report; a refused glyph row,
// a newline and a home give one status result. out_last marks the final result.
// An undefined opcode is taken and gives nothing.
// The front end takes one item per cycle into a four-entry descriptor queue while
// that queue is not full; the back end sends one result per cycle from its output
// register while out_pop is high. The first result of an item passes through the
// queue and the output register before it is on the out_ ports.
// cfg_we writes register cfg_index at once; write only while the block is idle.
// Synchronous reset homes the cursor, empties the queue and loads default config.
// While out_pop is low results wait in the output register, the queue fills, and
// then full rises.
`timescale 1ns / 1ps
module variable_width_glyph_blitter_unit
  import vwgb_pkg::*;
#(
  parameter int MAX_BOX_WIDTH_TILES  = DEF_MAX_BOX_W,
  parameter int MAX_BOX_HEIGHT_TILES = DEF_MAX_BOX_H
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         in_push,
  output logic         in_full,
  input  logic [1:0]   in_opcode,
  input  logic [3:0]   in_row_number,
  input  logic [63:0]  in_row_pixels,
  input  logic [3:0]   in_glyph_width,
  input  logic         in_is_marker,
  output logic         out_empty,
  input  logic         out_pop,
  output logic [1:0]   out_kind,
  output logic [16:0]  out_write_address,
  output logic [63:0]  out_or_data,
  output logic [8:0]   out_report_x,
  output logic [8:0]   out_report_y,
  output logic         out_last
);

  cfg_t  cfg_r, cfg_nxt;
  logic  accept;
  logic  q_push, q_pop, q_full, q_empty;
  desc_t q_din, q_dout;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_W: cfg_nxt.box_w =
          ({1'b0, cfg_data[5:0]} > 7'(MAX_BOX_WIDTH_TILES)) ?
          6'(MAX_BOX_WIDTH_TILES) : cfg_data[5:0];
        CFG_BOX_H: cfg_nxt.box_h =
          ({1'b0, cfg_data[4:0]} > 6'(MAX_BOX_HEIGHT_TILES)) ?
          5'(MAX_BOX_HEIGHT_TILES) : cfg_data[4:0];
        CFG_INK:   cfg_nxt.ink  = cfg_data[7:0];
        CFG_BASE:  cfg_nxt.base = cfg_data;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{box_w: RST_BOX_W, box_h: RST_BOX_H, ink: RST_INK, base: RST_BASE};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  vwgb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .opcode      (in_opcode),
    .row_number  (in_row_number),
    .row_pixels  (in_row_pixels),
    .glyph_width (in_glyph_width),
    .is_marker   (in_is_marker),
    .desc_push   (q_push),
    .desc        (q_din)
  );

  vwgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  vwgb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .desc              (q_dout),
    .desc_empty        (q_empty),
    .desc_pop          (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_kind          (out_kind),
    .out_write_address (out_write_address),
    .out_or_data       (out_or_data),
    .out_report_x      (out_report_x),
    .out_report_y      (out_report_y),
    .out_last          (out_last)
  );

endmodule

@@ dv/glyph_blit_checker.sv @@
// Checker for the glyph blitter: tracks cursor and config, predicts every result and compares.
`timescale 1ns / 1ps
module glyph_blit_checker
  import vwgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_row_number,
  input  logic [63:0] in_row_pixels,
  input  logic [3:0]  in_glyph_width,
  input  logic        in_is_marker,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_kind,
  input  logic [16:0] out_write_address,
  input  logic [63:0] out_or_data,
  input  logic [8:0]  out_report_x,
  input  logic [8:0]  out_report_y,
  input  logic        out_last,
  output int          fails,
  output int          outstanding
);

  typedef struct packed {
    kind_t       kind;
    logic [16:0] addr;
    logic [63:0] data;
    logic [8:0]  rx;
    logic [8:0]  ry;
    logic        last;
  } blit_t;

  blit_t due_q[$];
  int    err_count = 0;

  logic [4:0]  cur_row;
  logic [5:0]  cur_col;
  logic [2:0]  cur_off;
  logic        refused;
  logic [5:0]  box_w;
  logic [4:0]  box_h;
  logic [7:0]  ink;
  logic [15:0] base;

  function automatic logic [16:0] tile_addr(int trow, int tcol, int y);
    int a;
    a = int'(base) + 64 * (int'(box_w) * trow + tcol) + 8 * y;
    return a[16:0];
  endfunction

  task automatic post(kind_t k, logic [16:0] a, logic [63:0] d, logic [8:0] rx,
                      logic [8:0] ry, logic l);
    blit_t b;
    b.kind = k;
    b.addr = a;
    b.data = d;
    b.rx   = rx;
    b.ry   = ry;
    b.last = l;
    due_q.push_back(b);
  endtask

  task automatic apply_cfg(logic [1:0] idx, logic [15:0] d);
    case (idx)
      CFG_BOX_W: begin
        box_w = (d[5:0] > DEF_MAX_BOX_W) ? 6'(DEF_MAX_BOX_W) : d[5:0];
      end
      CFG_BOX_H: begin
        box_h = (d[4:0] > DEF_MAX_BOX_H) ? 5'(DEF_MAX_BOX_H) : d[4:0];
      end
      CFG_INK: begin
        ink = d[7:0];
      end
      default: begin
        base = d;
      end
    endcase
  endtask

  task automatic place_item(logic [1:0] op, logic [3:0] row, logic [63:0] pix,
                            logic [3:0] gw, logic mk);
    int          sh;
    int          trow;
    int          y;
    logic [63:0] masked;
    logic [63:0] left;
    logic [63:0] right;
    logic [4:0]  off_sum;
    if (op == OP_NEWLINE) begin
      if (cur_row + 2 >= box_h) begin
        post(KIND_REFUSED, '0, '0, '0, '0, 1'b1);
      end else begin
        cur_row = cur_row + 5'd2;
        cur_col = '0;
        cur_off = '0;
        post(KIND_ACCEPTED, '0, '0, '0, '0, 1'b1);
      end
    end else if (op == OP_HOME) begin
      cur_row = '0;
      cur_col = '0;
      cur_off = '0;
      post(KIND_ACCEPTED, '0, '0, '0, '0, 1'b1);
    end else if (op == OP_ROW) begin
      if (row == 0) begin
        refused = 1'b0;
        if (8 * cur_col + cur_off + gw >= 8 * box_w) begin
          if (cur_row + 2 >= box_h) begin
            refused = 1'b1;
          end else begin
            cur_row = cur_row + 5'd2;
            cur_col = '0;
            cur_off = '0;
          end
        end
      end
      if (refused) begin
        post(KIND_REFUSED, '0, '0, '0, '0, 1'b1);
      end else begin
        if (row == 0 && mk) begin
          post(KIND_REPORT, '0, '0, {cur_col, cur_off}, {cur_row, 4'b0}, 1'b0);
        end
        masked = pix & {8{ink}};
        sh     = 8 * cur_off;
        left   = masked << sh;
        right  = (sh != 0) ? (masked >> (64 - sh)) : 64'd0;
        trow   = cur_row + ((row >= GLYPH_HALF) ? 1 : 0);
        y      = row % GLYPH_HALF;
        post(KIND_WRITE, tile_addr(trow, cur_col, y), left, '0, '0, 1'b0);
        post(KIND_WRITE, tile_addr(trow, cur_col + 1, y), right, '0, '0, 1'b1);
        if (row == GLYPH_ROWS - 1) begin
          off_sum = cur_off + gw;
          cur_col = cur_col + off_sum[4:3];
          cur_off = off_sum[2:0];
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    blit_t want;
    if (!rst_n) begin
      cur_row = '0;
      cur_col = '0;
      cur_off = '0;
      refused = 1'b0;
      box_w   = RST_BOX_W;
      box_h   = RST_BOX_H;
      ink     = RST_INK;
      base    = RST_BASE;
      due_q.delete();
    end else begin
      if (!out_empty && out_pop) begin
        if (due_q.size() == 0) begin
          $error("result with nothing due: kind %0d addr 0x%0h", out_kind, out_write_address);
          err_count++;
        end else begin
          want = due_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("write_address", want.addr, out_write_address);
          check_field("or_data", want.data, out_or_data);
          check_field("report_x", want.rx, out_report_x);
          check_field("report_y", want.ry, out_report_y);
          check_field("last", want.last, out_last);
        end
      end
      if (cfg_we) apply_cfg(cfg_index, cfg_data);
      if (in_push && !in_full) begin
        place_item(in_opcode, in_row_number, in_row_pixels, in_glyph_width, in_is_marker);
      end
    end
    fails       <= err_count;
    outstanding <= due_q.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the glyph blitter: clock, reset, item and config stimulus, verdict.
`timescale 1ns / 1ps
module tb
  import vwgb_pkg::*;
();

  localparam int LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_opcode = '0;
  logic [3:0]  in_row_number = '0;
  logic [63:0] in_row_pixels = '0;
  logic [3:0]  in_glyph_width = '0;
  logic        in_is_marker = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [16:0] out_write_address;
  logic [63:0] out_or_data;
  logic [8:0]  out_report_x;
  logic [8:0]  out_report_y;
  logic        out_last;
  int          fails;
  int          outstanding;

  logic        no_idle = 1'b0;
  int          items_sent = 0;
  int          pop_wait = 0;
  int          cycles = 0;

  variable_width_glyph_blitter_unit dut (.*);

  glyph_blit_checker chk (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall before each pop
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_wait = 0;
    end else if (out_pop && !out_empty) begin
      pop_wait = no_idle ? 0 : $urandom_range(0, 9);
      out_pop <= (pop_wait == 0);
    end else if (!out_pop) begin
      if (pop_wait > 0) pop_wait = pop_wait - 1;
      if (pop_wait == 0) out_pop <= 1'b1;
    end
  end

  task automatic send(logic [1:0] op, logic [3:0] row, logic [63:0] pix,
                      logic [3:0] gw, logic mk);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_opcode      <= op;
    in_row_number  <= row;
    in_row_pixels  <= pix;
    in_glyph_width <= gw;
    in_is_marker   <= mk;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  // hold the sender until every result is out, then let the pipe go quiet
  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] w, logic [15:0] h, logic [15:0] k,
                            logic [15:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BOX_W;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_BOX_H;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_INK;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= CFG_BASE;
    cfg_data  <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_pix();
    return {$urandom, $urandom};
  endfunction

  task automatic send_rows(int r0, int r1, logic [3:0] gw, logic mk);
    for (int r = r0; r <= r1; r++) begin
      send(OP_ROW, 4'(r), rand_pix(), gw, (r == 0) ? mk : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(int target);
    int pick;
    int r0;
    int r1;
    while (items_sent < target) begin
      no_idle <= ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        send_rows(0, GLYPH_ROWS - 1, 4'($urandom_range(0, 8)), ($urandom_range(0, 3) == 0));
      end else if (pick < 78) begin
        send(OP_NEWLINE, 4'($urandom), rand_pix(), 4'($urandom_range(0, 8)), 1'($urandom));
      end else if (pick < 83) begin
        send(OP_HOME, 4'($urandom), rand_pix(), 4'($urandom_range(0, 8)), 1'($urandom));
      end else if (pick < 93) begin
        r0 = $urandom_range(0, GLYPH_ROWS - 1);
        r1 = $urandom_range(r0, GLYPH_ROWS - 1);
        send_rows(r0, r1, 4'($urandom_range(0, 8)), 1'($urandom));
      end else begin
        send(2'($urandom_range(0, 3)), 4'($urandom), rand_pix(),
             4'($urandom_range(0, 8)), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // marker glyph, extreme pixel rows, advance of 7 leaves an offset
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      send(OP_ROW, 4'(r), (r == 0) ? '1 : (r == 1) ? '0 : rand_pix(), 4'd7, (r == 0));
    end
    send(OP_ROW, 4'd3, '1, 4'd8, 1'b0);          // row with no row 0 before it
    send(OP_ROW, 4'd15, '1, 4'd8, 1'b1);         // advance without row 0
    send(2'd3, 4'd0, '1, 4'd8, 1'b1);            // undefined opcode
    send(OP_ROW, 4'd0, '1, 4'd0, 1'b1);          // zero-width marker row 0
    send(OP_NEWLINE, 4'd0, '0, 4'd0, 1'b0);
    send(OP_HOME, 4'd15, '1, 4'd15, 1'b1);
    settle();

    set_config(16'd1, 16'd2, 16'hFF, 16'hFFFF);   // tiny box, mostly refused
    run_phase(items_sent + 58);
    settle();
    set_config(16'd0, 16'd24, 16'h5A, 16'h1234);  // zero width
    run_phase(items_sent + 58);
    settle();
    set_config(16'd63, 16'd31, 16'h00, 16'h0000); // saturating sizes
    run_phase(items_sent + 58);
    settle();
    set_config(16'd32, 16'd24, 16'($urandom_range(0, 255)), 16'($urandom));
    run_phase(items_sent + 58);
    settle();
    set_config(16'($urandom_range(1, 32)), 16'($urandom_range(2, 24)),
               16'($urandom_range(0, 255)), 16'($urandom));
    run_phase(items_sent + 58);
    settle();
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(items_sent + 58);
    settle();

    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/vwgb_pkg.sv
src/vwgb_front.sv
src/vwgb_queue.sv
src/vwgb_back.sv
src/variable_width_glyph_blitter_unit.sv
dv/glyph_blit_checker.sv
dv/tb.sv
